// ===== rtl/core/ssml_pkg.sv =====
// Package for the sorted set membership lookup block.
// Holds the command codes and the status codes; no dependencies.
`timescale 1ns / 1ps
package ssml_pkg;
    typedef enum logic {
        CMD_APPEND = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;
endpackage

// ===== rtl/core/ssml_store.sv =====
// Key store memory for the sorted set membership lookup block.
// One write port and one read port with a registered read; uses ssml_pkg.
`timescale 1ns / 1ps
module ssml_store
    import ssml_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);
    logic [63:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/sorted_set_membership_lookup.sv =====
// Sorted set membership lookup. One beat is in flight at a time: start is taken only while busy
// is low, and the next beat can be taken in the cycle that shows the result. The result of an
// append is registered and shown in the cycle after it is taken; a lookup makes at most
// ceil(log2(count+1)) probes, each a read of entry mid and a compare. A lookup on an unsorted
// store first runs an insertion sort through the store's one read port and one write port.
// The receiver cannot stall. Synchronous active-low reset empties the store and marks it
// sorted.
`timescale 1ns / 1ps
module sorted_set_membership_lookup
    import ssml_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [63:0] i_key,
    output logic        o_strobe,
    output logic        o_found,
    output logic [63:0] o_match_value,
    output logic        o_status
);
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);

    // Sort: outer index i holds v; inner j walks down, reading entry j-1
    // and shifting it up while it exceeds v. Search reads entry mid in S_SE_RD and
    // compares the registered data in S_SE_CMP.
    typedef enum logic [3:0] {
        S_IDLE, S_SO_RD, S_SO_WV, S_SO_CMP_RD, S_SO_CMP, S_SE_RD, S_SE_CMP
    } t_state;

    t_state      r_state;
    logic [CW-1:0] r_count, r_i, r_j, r_lo, r_hi, r_mid;
    logic        r_sorted;
    logic [63:0] r_key, r_v;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;

    // Entry j-1 moves up only while j is above the bottom and the entry exceeds v.
    // At j = 0 the read data is ignored and v drops into entry 0.
    logic so_shift;
    assign so_shift = (r_j != '0) && (rdata > r_v);

    ssml_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic [CW-1:0] mid_c;
    assign mid_c = r_lo + ((r_hi - r_lo) >> 1);

    assign busy = (r_state != S_IDLE);

    always_comb begin
        we    = 1'b0;
        waddr = r_j[AW-1:0];
        wdata = r_v;
        raddr = r_mid[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                waddr = r_count[AW-1:0];
                wdata = i_key;
                we    = start && (i_cmd == CMD_APPEND) && (r_count != CW'(STORE_DEPTH));
            end
            S_SO_RD:     raddr = r_i[AW-1:0];
            S_SO_CMP_RD: raddr = r_j[AW-1:0] - AW'(1);
            S_SO_CMP: begin
                // Shift the larger key up, or drop v into its slot.
                we    = 1'b1;
                waddr = r_j[AW-1:0];
                wdata = so_shift ? rdata : r_v;
            end
            S_SE_RD: raddr = mid_c[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sorted <= 1'b1;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_key <= i_key;
                        if (i_cmd == CMD_APPEND) begin
                            o_strobe      <= 1'b1;
                            o_found       <= 1'b0;
                            o_match_value <= '0;
                            if (r_count == CW'(STORE_DEPTH)) begin
                                o_status <= STATUS_FULL;
                            end else begin
                                o_status <= STATUS_OK;
                                r_count  <= r_count + CW'(1);
                                r_sorted <= 1'b0;
                            end
                        end else begin
                            r_lo <= '0;
                            r_hi <= r_count;
                            r_i  <= CW'(1);
                            if (!r_sorted && r_count > CW'(1)) begin
                                r_state <= S_SO_RD;
                            end else begin
                                r_state <= S_SE_RD;
                            end
                        end
                    end
                end
                S_SO_RD: begin
                    r_j     <= r_i;
                    r_state <= S_SO_WV;
                end
                S_SO_WV: begin
                    r_v     <= rdata;
                    r_state <= S_SO_CMP_RD;
                end
                S_SO_CMP_RD: r_state <= S_SO_CMP;
                S_SO_CMP: begin
                    if (so_shift) begin
                        r_j     <= r_j - CW'(1);
                        r_state <= S_SO_CMP_RD;
                    end else if (r_i + CW'(1) < r_count) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_SO_RD;
                    end else begin
                        r_sorted <= 1'b1;
                        r_state  <= S_SE_RD;
                    end
                end
                S_SE_RD: begin
                    r_mid <= mid_c;
                    if (r_lo >= r_hi) begin
                        o_strobe      <= 1'b1;
                        o_found       <= 1'b0;
                        o_match_value <= '0;
                        o_status      <= STATUS_OK;
                        r_state       <= S_IDLE;
                    end else begin
                        r_state <= S_SE_CMP;
                    end
                end
                S_SE_CMP: begin
                    if (rdata == r_key) begin
                        o_strobe      <= 1'b1;
                        o_found       <= 1'b1;
                        o_match_value <= r_key;
                        o_status      <= STATUS_OK;
                        r_state       <= S_IDLE;
                    end else begin
                        if (rdata < r_key) r_lo <= r_mid + CW'(1);
                        else               r_hi <= r_mid;
                        r_state <= S_SE_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== bench/tb_sorted_set_membership_lookup.sv =====
// Testbench for the sorted set membership lookup block.
// It checks every result against a predictor of the store; it depends only on ssml_pkg
// and the block itself.
`timescale 1ns / 1ps
module tb_sorted_set_membership_lookup;
    import ssml_pkg::*;

    localparam int DEPTH = 1024;

    typedef struct {
        t_cmd        cmd;
        logic [63:0] key;
        bit          steady;    // no idle gap may follow this beat
    } t_request;

    typedef struct {
        logic        found;
        logic [63:0] match_value;
        logic        status;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cmd = CMD_APPEND;
    logic [63:0] i_key = '0;
    logic        o_strobe;
    logic        o_found;
    logic [63:0] o_match_value;
    logic        o_status;

    t_request    pending_requests[$];
    t_answer     awaited_answers[$];

    // The predictor's own copy of the stored keys and the sorted mark.
    logic [63:0] model_keys[$];
    bit          model_sorted = 1'b1;

    // Keys the generator has appended so far, used to aim lookups at hits.
    logic [63:0] known_keys[$];

    int          gap_left = 0;
    bit          failed = 1'b0;

    sorted_set_membership_lookup #(.STORE_DEPTH(DEPTH)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .o_strobe      (o_strobe),
        .o_found       (o_found),
        .o_match_value (o_match_value),
        .o_status      (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Works out the answer to one accepted beat and updates the predicted store.
    function automatic t_answer predict_answer(t_request req);
        t_answer ans;
        int lo;
        int hi;
        int mid;
        ans = '{found: 1'b0, match_value: '0, status: STATUS_OK};
        if (req.cmd == CMD_APPEND) begin
            if (model_keys.size() >= DEPTH) begin
                ans.status = STATUS_FULL;
            end else begin
                model_keys.push_back(req.key);
                model_sorted = 1'b0;
            end
        end else begin
            if (!model_sorted) begin
                model_keys.sort();
                model_sorted = 1'b1;
            end
            // Unsigned binary search over the sorted keys.
            lo = 0;
            hi = model_keys.size();
            while (lo < hi && !ans.found) begin
                mid = lo + (hi - lo) / 2;
                if (model_keys[mid] == req.key) begin
                    ans.found = 1'b1;
                    ans.match_value = req.key;
                end else if (model_keys[mid] < req.key) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
        end
        return ans;
    endfunction

    function automatic logic [63:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // Queues one beat for the driver and keeps the generator's key list in step.
    function automatic void queue_beat(t_cmd cmd, logic [63:0] key, bit steady = 1'b0);
        t_request req;
        req = '{cmd: cmd, key: key, steady: steady};
        pending_requests.push_back(req);
        if (cmd == CMD_APPEND && known_keys.size() < DEPTH)
            known_keys.push_back(key);
    endfunction

    // Driver: start stays high while a beat is offered. When a beat is taken,
    // the next one is offered at once or after a short random burst of idle.
    always @(posedge i_clk) begin
        t_request req;
        bit taken;
        taken = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                req = pending_requests.pop_front();
                awaited_answers.push_back(predict_answer(req));
                taken = 1'b1;
                if (!req.steady && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 4);
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if ((taken || !start) && pending_requests.size() > 0) begin
                start <= 1'b1;
                i_cmd <= pending_requests[0].cmd;
                i_key <= pending_requests[0].key;
            end else if (taken) begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest awaited answer.
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_strobe) begin
            if (awaited_answers.size() == 0) begin
                $error("result beat with no answer awaited");
                failed = 1'b1;
            end else begin
                exp_ans = awaited_answers.pop_front();
                if (o_found !== exp_ans.found) begin
                    $error("found: expected %0d, got %0d", exp_ans.found, o_found);
                    failed = 1'b1;
                end
                if (o_match_value !== exp_ans.match_value) begin
                    $error("match_value: expected %h, got %h",
                           exp_ans.match_value, o_match_value);
                    failed = 1'b1;
                end
                if (o_status !== exp_ans.status) begin
                    $error("status: expected %0d, got %0d", exp_ans.status, o_status);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        logic [63:0] probe;
        int fill_idx;

        // Directed part: empty store, extremes, duplicates, unsigned ordering.
        queue_beat(CMD_LOOKUP, 64'd0);
        queue_beat(CMD_LOOKUP, '1);
        queue_beat(CMD_APPEND, '1);
        queue_beat(CMD_APPEND, 64'd0);
        queue_beat(CMD_APPEND, 64'h8000_0000_0000_0000);
        queue_beat(CMD_APPEND, 64'd5);
        queue_beat(CMD_APPEND, 64'd3);
        queue_beat(CMD_APPEND, 64'd5);
        queue_beat(CMD_LOOKUP, 64'd5);
        queue_beat(CMD_LOOKUP, 64'd0);
        queue_beat(CMD_LOOKUP, '1);
        queue_beat(CMD_LOOKUP, 64'h8000_0000_0000_0000);
        queue_beat(CMD_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_beat(CMD_LOOKUP, 64'd4);
        queue_beat(CMD_LOOKUP, 64'd3);
        queue_beat(CMD_APPEND, 64'd1);
        queue_beat(CMD_LOOKUP, 64'd1);
        queue_beat(CMD_LOOKUP, 64'd2);

        // Random part: the store grows by a few dozen keys, half the lookups
        // aim at stored keys so that hits are frequent.
        repeat (150) begin
            if ($urandom_range(0, 99) < 40) begin
                queue_beat(CMD_APPEND, random_key());
            end else begin
                if ($urandom_range(0, 1) == 1)
                    probe = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else
                    probe = random_key();
                queue_beat(CMD_LOOKUP, probe);
            end
        end

        // Last part, with no idling: fill the store with keys above almost all
        // random ones so the sort stays cheap, then hit the full store.
        fill_idx = 0;
        while (known_keys.size() < DEPTH) begin
            queue_beat(CMD_APPEND, 64'hFFFF_FFFF_0000_0000 + fill_idx, 1'b1);
            fill_idx = fill_idx + 1;
            if (fill_idx % 32 == 0)
                queue_beat(CMD_LOOKUP, known_keys[$urandom_range(0, known_keys.size() - 1)],
                           1'b1);
        end
        repeat (6) queue_beat(CMD_APPEND, random_key(), 1'b1);
        repeat (20) begin
            if ($urandom_range(0, 1) == 1)
                probe = known_keys[$urandom_range(0, DEPTH - 1)];
            else
                probe = random_key();
            queue_beat(CMD_LOOKUP, probe, 1'b1);
        end
        queue_beat(CMD_LOOKUP, '1, 1'b1);
        queue_beat(CMD_APPEND, 64'd0, 1'b1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_requests.size() == 0 && !start);
        wait (awaited_answers.size() == 0);
        repeat (50) @(posedge i_clk);

        if (!failed && awaited_answers.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, sorts included.
    initial begin
        #30ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/ssml_pkg.sv
rtl/core/ssml_store.sv
rtl/core/sorted_set_membership_lookup.sv
bench/tb_sorted_set_membership_lookup.sv
